FILE: sv/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants of the packet block sequencer.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int SEQ_W  = 56;
  localparam int CNT_W  = 24;
  localparam int LEN_W  = 16;
  localparam int RING_W = 8;
  localparam int RBLK_W = 9;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 56;
  localparam int DVD_W  = 56;

  // input op codes
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_PPB      = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_OVERLAP  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_START    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RING     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_EXPECTED = 3'd4;

  localparam logic [CNT_W-1:0]  RST_PPB    = 24'd16384;
  localparam logic [RBLK_W-1:0] RST_RING   = 9'd24;
  localparam logic [SEQ_W-1:0]  RST_PREV   = 56'd2048;
  localparam logic [SEQ_W:0]    OK_MARGIN  = 57'd64;
  localparam logic [SEQ_W:0]    LATE_MARGIN = 57'd1048576;
  localparam logic [SEQ_W-1:0]  BACK_LIMIT = 56'd1024;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [1:0] {
    CL_PKT   = 2'd0,
    CL_START = 2'd1,
    CL_STOP  = 2'd2,
    CL_NONE  = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] ulen;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [RING_W-1:0] ring;
    logic [CNT_W-1:0]  off;
    logic [SEQ_W-1:0]  first;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  drop;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [RING_W-1:0] ring;
    logic [SEQ_W-1:0]  first;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  drops;
    logic [SEQ_W-1:0]  last;
    logic              empty;
  } slot_t;

endpackage

FILE: sv/packet_block_sequencer_top.sv
// ----------------------------------------------------------------------------
// packet_block_sequencer_top
// Packet capture sequencer: block boundaries, ring slots and block records.
// ----------------------------------------------------------------------------
// a block change waits on the bit-serial block-step remainder, and on a
// second remainder for the ring wrap when a slot is already open; START
// waits on a remainder to arm
// throughput: one item at a time in the back end; a packet holds it until
// its result words are out (longer under out_stall)
// reset: synchronous, returns control state and config to defaults
module packet_block_sequencer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [63:0]                 in_seq_word,
  input  logic [15:0]                 in_udp_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [7:0]                  out_ring_index,
  output logic [23:0]                 out_slot_offset,
  output logic [55:0]                 out_first_packet,
  output logic [23:0]                 out_packet_count,
  output logic [23:0]                 out_drop_count,
  output logic                        out_last_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [55:0]                 cfg_data
);

  logic                              q_valid, q_pop;
  pbs_pkg::item_t                    q_item;
  logic                              div_start, div_busy, div_done;
  logic [pbs_pkg::DVD_W-1:0]         div_dividend;
  logic [pbs_pkg::CNT_W-1:0]         div_divisor, div_rem;
  pbs_pkg::res_t                     res;

  assign cfg_ready = 1'b1;

  pbs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_seq_word, .in_udp_length,
    .q_valid, .q_item, .q_pop
  );

  pbs_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dividend), .divisor(div_divisor),
    .busy(div_busy), .done(div_done), .rem(div_rem)
  );

  pbs_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .cfg_valid, .cfg_index, .cfg_data,
    .div_start, .div_dividend, .div_divisor, .div_done, .div_rem,
    .out_valid, .out_stall, .out_res(res), .out_last(out_last_result)
  );

  assign out_kind         = res.kind;
  assign out_ring_index   = res.ring;
  assign out_slot_offset  = res.off;
  assign out_first_packet = res.first;
  assign out_packet_count = res.cnt;
  assign out_drop_count   = res.drop;

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !div_busy) else $error("divider done while still busy");

endmodule

FILE: sv/pbs_front.sv
// ----------------------------------------------------------------------------
// pbs_front
// Input side: accepts words, classifies the op and queues them (2 entries).
// ----------------------------------------------------------------------------
module pbs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [63:0]                   in_seq_word,
  input  logic [pbs_pkg::LEN_W-1:0]     in_udp_length,
  output logic                          q_valid,
  output pbs_pkg::item_t                q_item,
  input  logic                          q_pop
);

  pbs_pkg::item_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  pbs_pkg::item_t item_in;

  always_comb begin
    unique case (in_op)
      pbs_pkg::OP_PACKET: item_in.cls = pbs_pkg::CL_PKT;
      pbs_pkg::OP_START:  item_in.cls = pbs_pkg::CL_START;
      pbs_pkg::OP_STOP:   item_in.cls = pbs_pkg::CL_STOP;
      default:            item_in.cls = pbs_pkg::CL_NONE;
    endcase
    item_in.seq  = in_seq_word[pbs_pkg::SEQ_W-1:0];
    item_in.ulen = in_udp_length;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

FILE: sv/pbs_div.sv
// ----------------------------------------------------------------------------
// pbs_div
// Bit-serial remainder unit: 56-bit dividend modulo 24-bit divisor.
// ----------------------------------------------------------------------------
module pbs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pbs_pkg::DVD_W-1:0]   dividend,
  input  logic [pbs_pkg::CNT_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [pbs_pkg::CNT_W-1:0]   rem
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [5:0]                 cnt_r, cnt_nxt;
  logic [pbs_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [pbs_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [pbs_pkg::CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [pbs_pkg::CNT_W:0]    trial;

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;
  assign trial = {rem_r, dvd_r[pbs_pkg::DVD_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(pbs_pkg::DVD_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // one restoring step per cycle
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = pbs_pkg::CNT_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[pbs_pkg::CNT_W-1:0];
      end
      dvd_nxt = {dvd_r[pbs_pkg::DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

FILE: sv/pbs_back.sv
// ----------------------------------------------------------------------------
// pbs_back
// Execution side: capture state, active block slots, result register.
// ----------------------------------------------------------------------------
module pbs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  pbs_pkg::item_t                q_item,
  output logic                          q_pop,
  input  logic                          cfg_valid,
  input  logic [pbs_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [pbs_pkg::CDAT_W-1:0]    cfg_data,
  output logic                          div_start,
  output logic [pbs_pkg::DVD_W-1:0]     div_dividend,
  output logic [pbs_pkg::CNT_W-1:0]     div_divisor,
  input  logic                          div_done,
  input  logic [pbs_pkg::CNT_W-1:0]     div_rem,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pbs_pkg::res_t                 out_res,
  output logic                          out_last
);

  typedef enum logic [9:0] {
    S_WAIT  = 10'b0000000001,
    S_ARMW  = 10'b0000000010,
    S_LEN   = 10'b0000000100,
    S_ORDER = 10'b0000001000,
    S_STEPW = 10'b0000010000,
    S_RINGW = 10'b0000100000,
    S_NEW   = 10'b0001000000,
    S_WR0   = 10'b0010000000,
    S_WR1   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    RUN_IDLE   = 3'b001,
    RUN_ARMED  = 3'b010,
    RUN_RECORD = 3'b100
  } run_t;

  state_t st_r, st_nxt;
  run_t   run_r, run_nxt;

  logic [pbs_pkg::CNT_W-1:0]  ppb_r, ppb_nxt;
  logic [pbs_pkg::CNT_W-1:0]  ovl_r, ovl_nxt;
  logic [pbs_pkg::SEQ_W-1:0]  sidx_r, sidx_nxt;
  logic [pbs_pkg::RBLK_W-1:0] ring_r, ring_nxt;
  logic [pbs_pkg::LEN_W-1:0]  exp_r, exp_nxt;

  logic [pbs_pkg::SEQ_W-1:0]  armed_r, armed_nxt;
  logic [pbs_pkg::SEQ_W-1:0]  prev_r, prev_nxt;
  logic                       force_r, force_nxt;
  logic [pbs_pkg::SEQ_W:0]    nb_r, nb_nxt;
  logic [pbs_pkg::LEN_W-1:0]  learned_r, learned_nxt;
  pbs_pkg::slot_t             act_r [2];
  pbs_pkg::slot_t             act_nxt [2];
  pbs_pkg::item_t             item_r, item_nxt;
  pbs_pkg::res_t              rec_r [4];
  pbs_pkg::res_t              rec_nxt [4];
  logic [3:0]                 mask_r, mask_nxt;
  logic [pbs_pkg::SEQ_W-1:0]  firstn_r, firstn_nxt;
  logic [pbs_pkg::RING_W-1:0] newring_r, newring_nxt;
  logic                       oval_r, oval_nxt;
  pbs_pkg::res_t              ores_r, ores_nxt;
  logic                       olast_r, olast_nxt;

  logic [pbs_pkg::CNT_W-1:0]  eff_ppb, eff_step;
  logic [pbs_pkg::RBLK_W-1:0] eff_ring;
  logic [pbs_pkg::LEN_W-1:0]  expect_len, ulen_m8;
  logic [pbs_pkg::SEQ_W-1:0]  seq, back_dist, diff, dl;
  logic                       fnew, hit, wk, out_free;
  logic [1:0]                 sel;
  pbs_pkg::slot_t             ws;

  assign out_valid = oval_r;
  assign out_res   = ores_r;
  assign out_last  = olast_r;
  assign out_free  = !oval_r || !out_stall;

  assign eff_ppb  = (ppb_r == '0) ? 24'd1 : ppb_r;
  assign eff_step = (ovl_r < eff_ppb) ? (eff_ppb - ovl_r) : 24'd1;
  assign eff_ring = (ring_r == '0) ? 9'd1 : ((ring_r > 9'd256) ? 9'd256 : ring_r);
  assign seq      = item_r.seq;
  assign ulen_m8  = item_r.ulen - 16'd8;
  assign expect_len = (exp_r != '0) ? exp_r : learned_r;
  assign back_dist  = prev_r - seq;

  // slot under test in the write states
  assign wk   = (st_r == S_WR1);
  assign ws   = act_r[wk];
  assign diff = seq - ws.first;
  assign dl   = seq - ws.last;
  assign hit  = ws.valid && (seq >= ws.first) && (diff < {32'd0, eff_ppb});

  always_comb begin
    st_nxt      = st_r;
    run_nxt     = run_r;
    ppb_nxt     = ppb_r;
    ovl_nxt     = ovl_r;
    sidx_nxt    = sidx_r;
    ring_nxt    = ring_r;
    exp_nxt     = exp_r;
    armed_nxt   = armed_r;
    prev_nxt    = prev_r;
    force_nxt   = force_r;
    nb_nxt      = nb_r;
    learned_nxt = learned_r;
    act_nxt     = act_r;
    item_nxt    = item_r;
    rec_nxt     = rec_r;
    mask_nxt    = mask_r;
    firstn_nxt  = firstn_r;
    newring_nxt = newring_r;
    oval_nxt    = oval_r && out_stall;
    ores_nxt    = ores_r;
    olast_nxt   = olast_r;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    div_dividend = '0;
    div_divisor  = eff_ppb;
    fnew        = force_r;
    sel         = 2'd0;

    if (cfg_valid) begin
      unique case (cfg_index)
        pbs_pkg::CFG_PPB:      ppb_nxt  = cfg_data[pbs_pkg::CNT_W-1:0];
        pbs_pkg::CFG_OVERLAP:  ovl_nxt  = cfg_data[pbs_pkg::CNT_W-1:0];
        pbs_pkg::CFG_START:    sidx_nxt = cfg_data[pbs_pkg::SEQ_W-1:0];
        pbs_pkg::CFG_RING:     ring_nxt = cfg_data[pbs_pkg::RBLK_W-1:0];
        pbs_pkg::CFG_EXPECTED: exp_nxt  = cfg_data[pbs_pkg::LEN_W-1:0];
        default: ;
      endcase
    end

    unique case (st_r)
      S_WAIT: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          unique case (q_item.cls)
            pbs_pkg::CL_START: begin
              if (run_r != RUN_RECORD) begin
                for (int i = 0; i < 2; i++) begin
                  act_nxt[i].first = '0;
                  act_nxt[i].cnt   = '0;
                  act_nxt[i].drops = '0;
                  act_nxt[i].last  = '0;
                  act_nxt[i].empty = 1'b1;
                end
                div_start    = 1'b1;
                div_dividend = sidx_r;
                div_divisor  = eff_ppb;
                st_nxt       = S_ARMW;
              end
            end
            pbs_pkg::CL_STOP: run_nxt = RUN_IDLE;
            pbs_pkg::CL_PKT: begin
              if (run_r != RUN_IDLE) st_nxt = S_LEN;
            end
            default: ;
          endcase
        end
      end
      S_ARMW: begin
        if (div_done) begin
          armed_nxt = sidx_r - {32'd0, div_rem};
          run_nxt   = RUN_ARMED;
          st_nxt    = S_WAIT;
        end
      end
      S_LEN: begin
        st_nxt = S_WAIT;
        if (item_r.ulen >= 16'd8) begin
          if (expect_len == '0 || expect_len == ulen_m8) begin
            if (expect_len == '0) learned_nxt = ulen_m8;
            if (run_r == RUN_ARMED) begin
              if (seq >= armed_r && {1'b0, seq} < ({1'b0, armed_r} + pbs_pkg::OK_MARGIN)) begin
                run_nxt = RUN_RECORD;
                st_nxt  = S_ORDER;
              end else if ({1'b0, seq} < ({1'b0, armed_r} + pbs_pkg::LATE_MARGIN)) begin
                run_nxt = RUN_IDLE;
              end
            end else begin
              st_nxt = S_ORDER;
            end
          end
        end
      end
      S_ORDER: begin
        st_nxt = S_WR0;
        if (seq <= prev_r) begin
          if (back_dist > pbs_pkg::BACK_LIMIT) begin
            fnew = 1'b1;
          end else if (back_dist != '0) begin
            st_nxt = S_WAIT;
          end
        end else begin
          fnew = 1'b0;
        end
        if (st_nxt != S_WAIT) begin
          force_nxt = fnew;
          prev_nxt  = seq;
          if ({1'b0, seq} >= nb_r || fnew) begin
            div_start    = 1'b1;
            div_dividend = seq;
            div_divisor  = eff_step;
            st_nxt       = S_STEPW;
          end
        end
      end
      S_STEPW: begin
        if (div_done) begin
          firstn_nxt = seq - {32'd0, div_rem};
          if (act_r[0].valid) begin
            rec_nxt[0] = '{kind: pbs_pkg::KIND_FINISH, ring: act_r[0].ring, off: '0,
                           first: act_r[0].first, cnt: act_r[0].cnt,
                           drop: act_r[0].drops};
            mask_nxt[0] = 1'b1;
          end
          act_nxt[0] = act_r[1];
          if (act_r[1].valid) begin
            div_start    = 1'b1;
            div_dividend = {47'd0, {1'b0, act_r[1].ring} + 9'd1};
            div_divisor  = {15'd0, eff_ring};
            st_nxt       = S_RINGW;
          end else begin
            newring_nxt = '0;
            st_nxt      = S_NEW;
          end
        end
      end
      S_RINGW: begin
        if (div_done) begin
          newring_nxt = div_rem[pbs_pkg::RING_W-1:0];
          st_nxt      = S_NEW;
        end
      end
      S_NEW: begin
        act_nxt[1] = '{valid: 1'b1, ring: newring_r, first: firstn_r, cnt: '0,
                       drops: '0, last: '0, empty: 1'b1};
        nb_nxt = {1'b0, firstn_r} + {33'd0, eff_step};
        if (force_r) begin
          if (act_r[0].valid) begin
            rec_nxt[1] = '{kind: pbs_pkg::KIND_FINISH, ring: act_r[0].ring, off: '0,
                           first: act_r[0].first, cnt: act_r[0].cnt,
                           drop: act_r[0].drops};
            mask_nxt[1] = 1'b1;
          end
          act_nxt[0] = '{valid: 1'b0, ring: '0, first: '0, cnt: '0, drops: '0,
                         last: '0, empty: 1'b1};
        end
        st_nxt = S_WR0;
      end
      S_WR0, S_WR1: begin
        if (hit) begin
          rec_nxt[{1'b1, wk}] = '{kind: pbs_pkg::KIND_WRITE, ring: ws.ring,
                                  off: diff[pbs_pkg::CNT_W-1:0], first: ws.first,
                                  cnt: '0, drop: '0};
          mask_nxt[{1'b1, wk}] = 1'b1;
          if (ws.empty) begin
            act_nxt[wk].cnt   = diff[pbs_pkg::CNT_W-1:0] + 24'd1;
            act_nxt[wk].drops = diff[pbs_pkg::CNT_W-1:0];
            act_nxt[wk].empty = 1'b0;
            act_nxt[wk].last  = seq;
          end else if (seq > ws.last) begin
            act_nxt[wk].cnt   = ws.cnt + dl[pbs_pkg::CNT_W-1:0];
            act_nxt[wk].drops = ws.drops + dl[pbs_pkg::CNT_W-1:0] - 24'd1;
            act_nxt[wk].last  = seq;
          end
        end
        if (st_r == S_WR0) begin
          st_nxt = S_WR1;
        end else begin
          st_nxt = (mask_nxt != 4'd0) ? S_EMIT : S_WAIT;
        end
      end
      S_EMIT: begin
        for (int i = 3; i >= 0; i--) begin
          if (mask_r[i]) sel = 2'(i);
        end
        if (out_free) begin
          mask_nxt[sel] = 1'b0;
          oval_nxt      = 1'b1;
          ores_nxt      = rec_r[sel];
          olast_nxt     = (mask_nxt == 4'd0);
          if (mask_nxt == 4'd0) st_nxt = S_WAIT;
        end
      end
      default: st_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_WAIT;
      run_r     <= RUN_IDLE;
      ppb_r     <= pbs_pkg::RST_PPB;
      ovl_r     <= '0;
      sidx_r    <= '0;
      ring_r    <= pbs_pkg::RST_RING;
      exp_r     <= '0;
      armed_r   <= '0;
      prev_r    <= pbs_pkg::RST_PREV;
      force_r   <= 1'b0;
      nb_r      <= '0;
      learned_r <= '0;
      for (int i = 0; i < 2; i++) begin
        act_r[i] <= '{valid: 1'b0, ring: '0, first: '0, cnt: '0, drops: '0,
                      last: '0, empty: 1'b1};
      end
      mask_r    <= '0;
      oval_r    <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      run_r     <= run_nxt;
      ppb_r     <= ppb_nxt;
      ovl_r     <= ovl_nxt;
      sidx_r    <= sidx_nxt;
      ring_r    <= ring_nxt;
      exp_r     <= exp_nxt;
      armed_r   <= armed_nxt;
      prev_r    <= prev_nxt;
      force_r   <= force_nxt;
      nb_r      <= nb_nxt;
      learned_r <= learned_nxt;
      act_r     <= act_nxt;
      mask_r    <= mask_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    rec_r     <= rec_nxt;
    firstn_r  <= firstn_nxt;
    newring_r <= newring_nxt;
    ores_r    <= ores_nxt;
    olast_r   <= olast_nxt;
  end

endmodule

FILE: sim/pbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_checker
// Watches the config, packet and record channels of the packet block
// sequencer, predicts each record word from its own copy of the capture
// state and compares every delivered word field by field.
// ----------------------------------------------------------------------------
module pbs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_seq_word,
  input  logic [15:0] in_udp_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [7:0]  out_ring_index,
  input  logic [23:0] out_slot_offset,
  input  logic [55:0] out_first_packet,
  input  logic [23:0] out_packet_count,
  input  logic [23:0] out_drop_count,
  input  logic        out_last_result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [55:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {
    CAP_IDLE   = 2'd0,
    CAP_ARMED  = 2'd1,
    CAP_RECORD = 2'd2
  } cap_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ring;
    logic [23:0] off;
    logic [55:0] first;
    logic [23:0] cnt;
    logic [23:0] drop;
    logic        last;
  } rec_word_t;

  localparam longint unsigned SEQ_MASK = 64'h00FF_FFFF_FFFF_FFFF;

  // configuration copy
  logic [23:0] blk_pkts, ovl_pkts;
  logic [55:0] start_req;
  logic [8:0]  ring_cnt;
  logic [15:0] pay_len;

  // capture state copy
  cap_state_t      cap_state;
  longint unsigned arm_base, prev_seq, boundary;
  logic            jump_flag;
  logic [15:0]     learned_len;
  pbs_pkg::slot_t  slots [2];

  rec_word_t expected_words[$];
  rec_word_t item_words[$];

  assign pending = expected_words.size();

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic clear_stats(input int i);
    slots[i].cnt   = '0;
    slots[i].drops = '0;
    slots[i].last  = '0;
    slots[i].empty = 1'b1;
  endtask

  task automatic add_word(input logic kind, input longint unsigned ring,
                          input longint unsigned off, input longint unsigned first,
                          input longint unsigned cnt, input longint unsigned drop);
    rec_word_t w;
    w.kind  = kind;
    w.ring  = ring[7:0];
    w.off   = off[23:0];
    w.first = first[55:0];
    w.cnt   = cnt[23:0];
    w.drop  = drop[23:0];
    w.last  = 1'b0;
    item_words.push_back(w);
  endtask

  task automatic close_slot0();
    if (slots[0].valid)
      add_word(pbs_pkg::KIND_FINISH, slots[0].ring, 0, slots[0].first, slots[0].cnt,
               slots[0].drops);
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [63:0] word,
                              input logic [15:0] ulen);
    longint unsigned seq, p, stp, rn, e, back, lo;
    seq = word & SEQ_MASK;
    p   = (blk_pkts == 0) ? 1 : blk_pkts;
    stp = (ovl_pkts < p) ? p - ovl_pkts : 1;
    rn  = (ring_cnt == 0) ? 1 : (ring_cnt > 256) ? 256 : ring_cnt;
    item_words.delete();
    if (op == pbs_pkg::OP_START) begin
      if (cap_state != CAP_RECORD) begin
        for (int i = 0; i < 2; i++) begin
          slots[i].first = '0;
          clear_stats(i);
        end
        arm_base  = start_req - (start_req % p);
        cap_state = CAP_ARMED;
      end
      return;
    end
    if (op == pbs_pkg::OP_STOP) begin
      cap_state = CAP_IDLE;
      return;
    end
    if (op == pbs_pkg::OP_UNUSED || cap_state == CAP_IDLE) return;
    if (ulen < 8) return;
    e = (pay_len != 0) ? pay_len : learned_len;
    if (e == 0) learned_len = ulen - 16'd8;
    else if (e != ulen - 8) return;

    if (cap_state == CAP_ARMED) begin
      if (seq >= arm_base && seq < arm_base + 64) begin
        cap_state = CAP_RECORD;
      end else begin
        if (seq < arm_base + (64'd1 << 20)) cap_state = CAP_IDLE;
        return;
      end
    end

    if (seq <= prev_seq) begin
      back = prev_seq - seq;
      if (back > 1024) jump_flag = 1'b1;
      else if (back != 0) return;
    end else begin
      jump_flag = 1'b0;
    end
    prev_seq = seq;

    // block boundary: retire the oldest slot, open a fresh one
    if (seq >= boundary || jump_flag) begin
      close_slot0();
      slots[0] = slots[1];
      slots[1].ring  = slots[1].valid ? 8'((longint'(slots[1].ring) + 1) % rn) : 8'd0;
      slots[1].valid = 1'b1;
      slots[1].first = 56'(seq - (seq % stp));
      clear_stats(1);
      boundary = longint'(slots[1].first) + stp;
      if (jump_flag) begin
        close_slot0();
        slots[0] = '0;
        slots[0].empty = 1'b1;
      end
    end

    for (int i = 0; i < 2; i++) begin
      lo = slots[i].first;
      if (!slots[i].valid || seq < lo || seq >= lo + p) continue;
      add_word(pbs_pkg::KIND_WRITE, slots[i].ring, seq - lo, lo, 0, 0);
      if (slots[i].empty) begin
        slots[i].cnt   = 24'(seq - lo + 1);
        slots[i].drops = 24'(seq - lo);
        slots[i].empty = 1'b0;
        slots[i].last  = 56'(seq);
      end else if (seq > slots[i].last) begin
        slots[i].cnt   = 24'(slots[i].cnt + (seq - slots[i].last));
        slots[i].drops = 24'(slots[i].drops + (seq - slots[i].last - 1));
        slots[i].last  = 56'(seq);
      end
    end

    if (item_words.size() > 0) item_words[$].last = 1'b1;
    foreach (item_words[k]) expected_words.push_back(item_words[k]);
  endtask

  always @(posedge clk) begin
    rec_word_t w;
    if (!rst_n) begin
      blk_pkts    = pbs_pkg::RST_PPB;
      ovl_pkts    = '0;
      start_req   = '0;
      ring_cnt    = pbs_pkg::RST_RING;
      pay_len     = '0;
      cap_state   = CAP_IDLE;
      arm_base    = 0;
      prev_seq    = pbs_pkg::RST_PREV;
      boundary    = 0;
      jump_flag   = 1'b0;
      learned_len = '0;
      for (int i = 0; i < 2; i++) begin
        slots[i] = '0;
        slots[i].empty = 1'b1;
      end
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pbs_pkg::CFG_PPB:      blk_pkts  = cfg_data[23:0];
          pbs_pkg::CFG_OVERLAP:  ovl_pkts  = cfg_data[23:0];
          pbs_pkg::CFG_START:    start_req = cfg_data;
          pbs_pkg::CFG_RING:     ring_cnt  = cfg_data[8:0];
          pbs_pkg::CFG_EXPECTED: pay_len   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(in_op, in_seq_word, in_udp_length);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("unexpected word kind", out_kind, 0);
        end else begin
          w = expected_words.pop_front();
          if (out_kind !== w.kind) report("kind", out_kind, w.kind);
          if (out_ring_index !== w.ring) report("ring_index", out_ring_index, w.ring);
          if (out_slot_offset !== w.off) report("slot_offset", out_slot_offset, w.off);
          if (out_first_packet !== w.first) report("first_packet", out_first_packet, w.first);
          if (out_packet_count !== w.cnt) report("packet_count", out_packet_count, w.cnt);
          if (out_drop_count !== w.drop) report("drop_count", out_drop_count, w.drop);
          if (out_last_result !== w.last) report("last_result", out_last_result, w.last);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

FILE: sim/tb_packet_block_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_block_sequencer_top
// Drives packet streams and START/STOP commands through several block, ring
// and length settings with bursty input and a stalling record consumer.
// ----------------------------------------------------------------------------
module tb_packet_block_sequencer_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = pbs_pkg::OP_PACKET;
  logic [63:0] in_seq_word = '0;
  logic [15:0] in_udp_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_ring_index;
  logic [23:0] out_slot_offset;
  logic [55:0] out_first_packet;
  logic [23:0] out_packet_count;
  logic [23:0] out_drop_count;
  logic        out_last_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [55:0] cfg_data = '0;

  int fail_count, pending;
  int cycles = 0;
  int burst_left = 0;
  logic [15:0] good_ulen;
  logic [15:0] learned_pay;
  logic [55:0] cur_seq, arm_seq;

  packet_block_sequencer_top u_top (.*);

  pbs_checker u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("packet_block_sequencer_top test failed");
      $finish;
    end
  end

  // consumer stall pattern rotates through four modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case ((cycles >> 7) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= (cycles % 5 < 2);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  task automatic put_word(input logic [1:0] op, input logic [63:0] word,
                          input logic [15:0] ulen);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_seq_word   <= word;
    in_udp_length <= ulen;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_packet(input logic [55:0] seq);
    put_word(pbs_pkg::OP_PACKET, {8'($urandom), seq}, good_ulen);
  endtask

  task automatic put_cmd(input logic [1:0] op);
    put_word(op, {$urandom, $urandom}, 16'($urandom));
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [55:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // rearm and hit the capture window
  task automatic rearm();
    put_cmd(pbs_pkg::OP_START);
    cur_seq = arm_seq + $urandom_range(0, 63);
    put_packet(cur_seq);
  endtask

  task automatic run_phase(input logic [23:0] ppb, input logic [23:0] ovl,
                           input logic [55:0] start, input logic [8:0] ring,
                           input logic [15:0] pay, input int n_items);
    longint unsigned p, span;
    int r;
    wait_quiet();
    cfg_write(pbs_pkg::CFG_PPB, 56'(ppb));
    cfg_write(pbs_pkg::CFG_OVERLAP, 56'(ovl));
    cfg_write(pbs_pkg::CFG_START, start);
    cfg_write(pbs_pkg::CFG_RING, 56'(ring));
    cfg_write(pbs_pkg::CFG_EXPECTED, 56'(pay));
    p = (ppb == 0) ? 1 : ppb;
    span = (3 * p > 100000) ? 100000 : 3 * p + 4;
    arm_seq = 56'(start - (start % p));
    good_ulen = ((pay != 0) ? pay : learned_pay) + 16'd8;
    put_cmd(pbs_pkg::OP_STOP);
    rearm();
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        cur_seq += $urandom_range(1, 3);
        put_packet(cur_seq);
      end else if (r < 63) begin
        put_packet(cur_seq);
      end else if (r < 70) begin
        put_packet(cur_seq - $urandom_range(1, 1024));
      end else if (r < 74) begin
        cur_seq -= $urandom_range(1025, 5000);
        put_packet(cur_seq);
      end else if (r < 82) begin
        cur_seq += $urandom_range(4, span);
        put_packet(cur_seq);
      end else if (r < 88) begin
        case ($urandom_range(0, 2))
          0: put_word(pbs_pkg::OP_PACKET, {$urandom, $urandom}, 16'($urandom));
          1: put_word(pbs_pkg::OP_PACKET, {$urandom, $urandom},
                      16'($urandom_range(0, 7)));
          default: put_word(pbs_pkg::OP_UNUSED, {$urandom, $urandom}, good_ulen);
        endcase
      end else if (r < 92) begin
        put_cmd(pbs_pkg::OP_STOP);
        rearm();
      end else if (r < 96) begin
        // armed but off the window: late goes idle, far ahead is dropped
        put_cmd(pbs_pkg::OP_STOP);
        put_cmd(pbs_pkg::OP_START);
        if ($urandom_range(0, 1))
          put_packet(arm_seq + $urandom_range(64, 100000));
        else
          put_packet(arm_seq + 56'd2000000 + $urandom_range(0, 1000));
        rearm();
      end else begin
        put_cmd(pbs_pkg::OP_START);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: learn the length, then the per-packet special cases
    learned_pay = 16'($urandom_range(1, 1500));
    cfg_write(pbs_pkg::CFG_PPB, 56'd4);
    cfg_write(pbs_pkg::CFG_OVERLAP, 56'd1);
    cfg_write(pbs_pkg::CFG_START, 56'd1000);
    cfg_write(pbs_pkg::CFG_RING, 56'd3);
    cfg_write(pbs_pkg::CFG_EXPECTED, 56'd0);
    arm_seq = 56'd1000;
    good_ulen = learned_pay + 16'd8;
    put_cmd(pbs_pkg::OP_STOP);
    put_packet(56'd1001);
    put_cmd(pbs_pkg::OP_START);
    put_packet(56'd1002);
    put_packet(56'd1002);
    put_packet(56'd1001);
    put_packet(56'd1003);
    put_word(pbs_pkg::OP_PACKET, {8'hA5, 56'd1004}, good_ulen + 16'd1);
    put_word(pbs_pkg::OP_PACKET, {8'h5A, 56'd1004}, 16'd5);
    put_word(pbs_pkg::OP_UNUSED, {8'hFF, 56'd1004}, good_ulen);
    put_packet(56'd1009);
    put_cmd(pbs_pkg::OP_START);
    put_packet(56'd20);
    put_packet(56'd21);
    put_packet(56'd30);
    put_cmd(pbs_pkg::OP_STOP);
    put_cmd(pbs_pkg::OP_START);
    put_packet(56'd1000);
    put_packet(56'd1003);

    // top of the sequence space with single-packet blocks and one ring slot
    wait_quiet();
    cfg_write(pbs_pkg::CFG_PPB, 56'd1);
    cfg_write(pbs_pkg::CFG_OVERLAP, 56'd0);
    cfg_write(pbs_pkg::CFG_START, 56'hFF_FFFF_FFFF_FFFF);
    cfg_write(pbs_pkg::CFG_RING, 56'd1);
    cfg_write(pbs_pkg::CFG_EXPECTED, 56'd65527);
    good_ulen = 16'hFFFF;
    put_cmd(pbs_pkg::OP_START);
    put_word(pbs_pkg::OP_PACKET, 64'hFFFF_FFFF_FFFF_FFFF, good_ulen);
    put_packet(56'd0);
    put_packet(56'd1);

    run_phase(24'd4, 24'd1, 56'($urandom) << 20, 9'd3, 16'd0, 18);
    run_phase(24'd1, 24'd0, 56'hFF_FFFF_FFFF_FFC0, 9'd511, 16'd65527, 15);
    run_phase(24'hFF_FFFF, 24'hFF_FFFE, 56'd0, 9'd256, 16'd100, 15);
    run_phase(24'd0, 24'd5, 56'({$urandom, $urandom}), 9'd0, 16'd0, 15);
    run_phase(24'd8, 24'd3, 56'({$urandom, $urandom}), 9'd511, 16'd1024, 15);
    run_phase(24'd5, 24'd9, 56'd777, 9'd2, 16'd0, 12);
    begin
      logic [23:0] rp;
      rp = $urandom_range(1, 64);
      run_phase(rp, 24'($urandom_range(0, rp - 1)), 56'({$urandom, $urandom}),
                9'($urandom_range(1, 256)), 16'($urandom_range(1, 9000)), 20);
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("packet_block_sequencer_top test passed");
    end else begin
      $display("packet_block_sequencer_top test failed");
    end
    $finish;
  end

endmodule
